// ===== hw/rtl/bta_pkg.sv =====
// ----------------------------------------------------------------------------
// bta_pkg - shared types and codes of the Beaver-triple AND gate
// Request selectors, result kinds, status codes and the command bundle
// that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int FIELD_W = 64;

  // request selector (in_tuser)
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_PEER  = 2'd2;

  // result kind (out_tuser)
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_MASK = 2'd1;
  localparam logic [1:0] KIND_PROD = 2'd2;

  // result status
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_NO_START  = 2'd3;

  // payload selection for the output register
  localparam logic [1:0] PAY_ZERO = 2'd0;
  localparam logic [1:0] PAY_MASK = 2'd1;
  localparam logic [1:0] PAY_PROD = 2'd2;

  typedef struct packed {
    logic       mem_wr;      // append the incoming triple
    logic       mem_rd;      // read the next triple, capture local shares
    logic       start_fin;   // latch held triple and own masked words
    logic       out_load;    // load the output register
    logic [1:0] out_kind;
    logic [1:0] out_status;
    logic [1:0] pay_sel;
  } dp_cmd_t;

endpackage

// ===== hw/rtl/beaver_triple_and_gate.sv =====
// ----------------------------------------------------------------------------
// beaver_triple_and_gate - one party's share of a bitwise AND
// Preloaded Beaver triples mask the local shares (d = x^a, e = y^b); the
// partner's masked words then yield z = (a&E)^(b&D)^c, plus D&E on party 0.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload
//  --------+-----------+-----------------------------------------------------
//  in_     | slave     | tuser req_type; tdata a, b, c, x, y, peer d, peer e
//  out_    | master    | tuser result_kind; tdata status, send d/e, product
//  cfg_    | slave     | tdata party_role (always ready)
//
//  For load and peer requests the result is registered at the accepting edge.
//  An unused selector is taken and answered with nothing. A start with a
//  triple available first passes the registered read of the triple store in
//  ST_FETCH. A start with the store used up is answered at the accepting
//  edge. The block takes one transaction at a time.
//  in_tready drops while a start waits on its store read and while a result
//  sits unaccepted in the output register. Synchronous reset empties the
//  store logically (fill and consume counters cleared) and clears role 0.
//
module beaver_triple_and_gate #(
  parameter int TRIPLE_DEPTH = 1024,
  parameter int WORD_WIDTH   = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  // input transaction
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [447:0] in_tdata,   // trip_a, trip_b, trip_c, share_x, share_y, peer_d, peer_e
  input  logic [1:0]   in_tuser,   // req_type
  // result transaction
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [199:0] out_tdata,  // status, send_d, send_e, prod_share, 6 zero bits
  output logic [1:0]   out_tuser,  // result_kind
  // role register write
  input  logic         cfg_tvalid,
  output logic         cfg_tready,
  input  logic         cfg_tdata   // party_role
);

  localparam int AW = (TRIPLE_DEPTH > 1) ? $clog2(TRIPLE_DEPTH) : 1;
  localparam int CW = $clog2(TRIPLE_DEPTH + 1);
  localparam int FW = bta_pkg::FIELD_W;

  bta_pkg::dp_cmd_t cmd;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [1:0]       res_status;
  logic [FW-1:0]    res_send_d, res_send_e, res_prod;

  // role register is never busy
  assign cfg_tready = 1'b1;

  bta_ctrl #(
    .TRIPLE_DEPTH(TRIPLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .req_type  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  bta_dp #(
    .TRIPLE_DEPTH(TRIPLE_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH),
    .AW          (AW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .trip_a    (in_tdata[63:0]),
    .trip_b    (in_tdata[127:64]),
    .trip_c    (in_tdata[191:128]),
    .share_x   (in_tdata[255:192]),
    .share_y   (in_tdata[319:256]),
    .peer_d    (in_tdata[383:320]),
    .peer_e    (in_tdata[447:384]),
    .cfg_we    (cfg_tvalid && cfg_tready),
    .cfg_role  (cfg_tdata),
    .res_kind  (out_tuser),
    .res_status(res_status),
    .res_send_d(res_send_d),
    .res_send_e(res_send_e),
    .res_prod  (res_prod)
  );

  // pack result fields, lowest first, pad to whole bytes
  assign out_tdata = {6'd0, res_prod, res_send_e, res_send_d, res_status};

endmodule

// ===== hw/rtl/bta_dp.sv =====
// ----------------------------------------------------------------------------
// bta_dp - datapath of the Beaver-triple AND gate
// Triple store, held triple, own masked words, role register and the
// output payload register.
// ----------------------------------------------------------------------------
module bta_dp #(
  parameter int TRIPLE_DEPTH = 1024,
  parameter int WORD_WIDTH   = 64,
  parameter int AW           = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bta_pkg::dp_cmd_t            cmd,
  input  logic [AW-1:0]               wr_addr,
  input  logic [AW-1:0]               rd_addr,
  input  logic [bta_pkg::FIELD_W-1:0] trip_a,
  input  logic [bta_pkg::FIELD_W-1:0] trip_b,
  input  logic [bta_pkg::FIELD_W-1:0] trip_c,
  input  logic [bta_pkg::FIELD_W-1:0] share_x,
  input  logic [bta_pkg::FIELD_W-1:0] share_y,
  input  logic [bta_pkg::FIELD_W-1:0] peer_d,
  input  logic [bta_pkg::FIELD_W-1:0] peer_e,
  input  logic                        cfg_we,
  input  logic                        cfg_role,
  output logic [1:0]                  res_kind,
  output logic [1:0]                  res_status,
  output logic [bta_pkg::FIELD_W-1:0] res_send_d,
  output logic [bta_pkg::FIELD_W-1:0] res_send_e,
  output logic [bta_pkg::FIELD_W-1:0] res_prod
);

  logic [WORD_WIDTH-1:0] mem_a [TRIPLE_DEPTH];
  logic [WORD_WIDTH-1:0] mem_b [TRIPLE_DEPTH];
  logic [WORD_WIDTH-1:0] mem_c [TRIPLE_DEPTH];

  logic [WORD_WIDTH-1:0] rd_a_r, rd_b_r, rd_c_r;
  logic [WORD_WIDTH-1:0] x_r, y_r;
  logic [WORD_WIDTH-1:0] held_a_r, held_b_r, held_c_r;
  logic [WORD_WIDTH-1:0] own_d_r, own_e_r;
  logic                  role_r;

  logic [1:0]            kind_r, status_r;
  logic [WORD_WIDTH-1:0] send_d_r, send_e_r, prod_r;

  logic [WORD_WIDTH-1:0] mask_d, mask_e, dd, ee, z;

  // store: one write and one registered read port per word
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem_a[wr_addr] <= trip_a[WORD_WIDTH-1:0];
      mem_b[wr_addr] <= trip_b[WORD_WIDTH-1:0];
      mem_c[wr_addr] <= trip_c[WORD_WIDTH-1:0];
    end
    if (cmd.mem_rd) begin
      rd_a_r <= mem_a[rd_addr];
      rd_b_r <= mem_b[rd_addr];
      rd_c_r <= mem_c[rd_addr];
      x_r    <= share_x[WORD_WIDTH-1:0];
      y_r    <= share_y[WORD_WIDTH-1:0];
    end
  end

  always_comb begin
    mask_d = x_r ^ rd_a_r;
    mask_e = y_r ^ rd_b_r;
    dd     = own_d_r ^ peer_d[WORD_WIDTH-1:0];
    ee     = own_e_r ^ peer_e[WORD_WIDTH-1:0];
    z      = (held_a_r & ee) ^ (held_b_r & dd) ^ held_c_r;
    if (!role_r) begin
      z = z ^ (dd & ee);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_fin) begin
      held_a_r <= rd_a_r;
      held_b_r <= rd_b_r;
      held_c_r <= rd_c_r;
      own_d_r  <= mask_d;
      own_e_r  <= mask_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r <= 1'b0;
    end else if (cfg_we) begin
      role_r <= cfg_role;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind_r   <= cmd.out_kind;
      status_r <= cmd.out_status;
      send_d_r <= '0;
      send_e_r <= '0;
      prod_r   <= '0;
      case (cmd.pay_sel)
        bta_pkg::PAY_MASK: begin
          send_d_r <= mask_d;
          send_e_r <= mask_e;
        end
        bta_pkg::PAY_PROD: begin
          prod_r <= z;
        end
        default: begin
        end
      endcase
    end
  end

  assign res_kind   = kind_r;
  assign res_status = status_r;
  assign res_send_d = bta_pkg::FIELD_W'(send_d_r);
  assign res_send_e = bta_pkg::FIELD_W'(send_e_r);
  assign res_prod   = bta_pkg::FIELD_W'(prod_r);

endmodule

// ===== hw/rtl/bta_ctrl.sv =====
// ----------------------------------------------------------------------------
// bta_ctrl - controller of the Beaver-triple AND gate
// Decodes requests, keeps the fill and consume counters and the pending
// flag, sequences the triple read and owns the output valid.
// ----------------------------------------------------------------------------
module bta_ctrl #(
  parameter int TRIPLE_DEPTH = 1024,
  parameter int AW           = 10,
  parameter int CW           = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [1:0]       req_type,
  output logic             out_tvalid,
  input  logic             out_tready,
  output bta_pkg::dp_cmd_t cmd,
  output logic [AW-1:0]    wr_addr,
  output logic [AW-1:0]    rd_addr
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FETCH = 1'b1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TRIPLE_DEPTH);

  logic          state_r, state_nxt;
  logic [CW-1:0] loaded_r, loaded_nxt;
  logic [CW-1:0] next_r, next_nxt;
  logic          pend_r, pend_nxt;
  logic          valid_r, valid_nxt;
  logic          slot_free, accept;

  assign slot_free = !valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign accept    = in_tvalid && in_tready;
  assign wr_addr   = loaded_r[AW-1:0];
  assign rd_addr   = next_r[AW-1:0];
  assign out_tvalid = valid_r;

  always_comb begin
    state_nxt  = state_r;
    loaded_nxt = loaded_r;
    next_nxt   = next_r;
    pend_nxt   = pend_r;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (req_type)
            bta_pkg::REQ_LOAD: begin
              cmd.out_load = 1'b1;
              cmd.out_kind = bta_pkg::KIND_LOAD;
              if (loaded_r == DEPTH_C) begin
                cmd.out_status = bta_pkg::STAT_FULL;
              end else begin
                cmd.mem_wr = 1'b1;
                loaded_nxt = loaded_r + 1'b1;
              end
            end
            bta_pkg::REQ_START: begin
              if (next_r >= loaded_r) begin
                cmd.out_load   = 1'b1;
                cmd.out_kind   = bta_pkg::KIND_MASK;
                cmd.out_status = bta_pkg::STAT_EXHAUSTED;
              end else begin
                cmd.mem_rd = 1'b1;
                next_nxt   = next_r + 1'b1;
                state_nxt  = ST_FETCH;
              end
            end
            bta_pkg::REQ_PEER: begin
              cmd.out_load = 1'b1;
              cmd.out_kind = bta_pkg::KIND_PROD;
              if (!pend_r) begin
                cmd.out_status = bta_pkg::STAT_NO_START;
              end else begin
                cmd.pay_sel = bta_pkg::PAY_PROD;
                pend_nxt    = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        // read data is in; wait for room in the output register
        if (slot_free) begin
          cmd.start_fin = 1'b1;
          cmd.out_load  = 1'b1;
          cmd.out_kind  = bta_pkg::KIND_MASK;
          cmd.pay_sel   = bta_pkg::PAY_MASK;
          pend_nxt      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      loaded_r <= '0;
      next_r   <= '0;
      pend_r   <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      loaded_r <= loaded_nxt;
      next_r   <= next_nxt;
      pend_r   <= pend_nxt;
      valid_r  <= valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/bta_checker.sv =====
// ----------------------------------------------------------------------------
// bta_checker - port-level checks of the Beaver-triple AND gate
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module bta_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [199:0] out_tdata,
  input logic [1:0]   out_tuser
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // reset drops any result
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a blocked result register stops intake
  a_no_intake: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("transaction taken with result register blocked");

  // load acknowledges carry no words
  a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == bta_pkg::KIND_LOAD |-> out_tdata[199:2] == '0)
    else $error("load acknowledge carries data");

  // missing start is only reported on product results
  a_nostart_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == bta_pkg::STAT_NO_START
      |-> out_tuser == bta_pkg::KIND_PROD)
    else $error("no-start status on wrong result kind");

endmodule

bind beaver_triple_and_gate bta_checker u_bta_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
